// ===== rtl/core/neighbour_gray_separation_assert.svh =====
// assertion macros for the neighbour gray separation block
`ifndef NEIGHBOUR_GRAY_SEPARATION_ASSERT_SVH
`define NEIGHBOUR_GRAY_SEPARATION_ASSERT_SVH

`ifndef SYNTH

// property that must hold at every clock edge outside reset
`define NGS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("neighbour gray separation check failed");

// property that must never hold outside reset
`define NGS_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(prop)) \
    else $error("neighbour gray separation forbidden condition");

`else

`define NGS_ASSERT(lbl, clk, rstn, prop)

`define NGS_ASSERT_NEVER(lbl, clk, rstn, prop)

`endif

`endif

// ===== rtl/core/ngs_pkg.sv =====
// shared types and constants of the neighbour gray separation block
package ngs_pkg;

  localparam int PixW     = 8;
  localparam int ColW     = 10;
  localparam int RowW     = 16;
  localparam int WidthW   = 11;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int MinDim   = 3;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_IMAGE_HEIGHT    = 2'd1,
    CFG_EIGHT_CONNECTED = 2'd2,
    CFG_SEPARATION_MODE = 2'd3
  } cfg_idx_e;

  // separation modes
  typedef enum logic [1:0] {
    MODE_LOWER   = 2'd0,
    MODE_HIGHER  = 2'd1,
    MODE_NEAREST = 2'd2
  } sep_mode_e;

  // one window column, top row oldest line
  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] bot;
  } col_t;

  // settings seen by the contrast unit
  typedef struct packed {
    logic       eight_connected;
    logic [1:0] separation_mode;
  } sep_cfg_t;

  // per-pixel bookkeeping carried down the pipeline
  typedef struct packed {
    logic            emit;
    logic [ColW-1:0] column;
    logic [RowW-1:0] row;
    logic            last;
  } meta_t;

  // one result item
  typedef struct packed {
    logic [PixW-1:0] separation;
    logic [ColW-1:0] column;
    logic [RowW-1:0] row;
    logic            last;
  } res_t;

endpackage

// ===== rtl/core/ngs_line_store.sv =====
// two line stores holding the previous two image rows
module ngs_line_store #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [AddrW-1:0]         rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [AddrW-1:0]         wr_addr_i,
  input  logic [ngs_pkg::PixW-1:0] wr_pixel_i,
  output logic [ngs_pkg::PixW-1:0] upper_o,
  output logic [ngs_pkg::PixW-1:0] middle_o
);
  import ngs_pkg::*;

  logic [PixW-1:0] upper_mem  [Depth];
  logic [PixW-1:0] middle_mem [Depth];
  logic [PixW-1:0] upper_q;
  logic [PixW-1:0] middle_q;

  // registered reads of both rows at the incoming column
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      upper_q  <= upper_mem[rd_addr_i];
      middle_q <= middle_mem[rd_addr_i];
    end
  end

  // middle row moves up, new pixel becomes the middle row
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i]  <= middle_q;
      middle_mem[wr_addr_i] <= wr_pixel_i;
    end
  end

  assign upper_o  = upper_q;
  assign middle_o = middle_q;

endmodule

// ===== rtl/core/ngs_col_cell.sv =====
// one column of the 3x3 window, shifting into its left neighbour
module ngs_col_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  ngs_pkg::col_t col_i,
  output ngs_pkg::col_t col_o
);
  import ngs_pkg::*;

  col_t col_q;

  // take the column from the right-hand neighbour
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ===== rtl/core/ngs_contrast.sv =====
// nearest lower and higher neighbour search and separation select
module ngs_contrast (
  input  ngs_pkg::col_t            left_i,
  input  ngs_pkg::col_t            centre_i,
  input  ngs_pkg::col_t            right_i,
  input  ngs_pkg::sep_cfg_t        cfg_i,
  output logic [ngs_pkg::PixW-1:0] separation_o
);
  import ngs_pkg::*;

  logic [PixW-1:0] centre;
  logic [PixW-1:0] nb [8];
  logic [7:0]      use_nb;
  logic [PixW-1:0] lower;
  logic [PixW-1:0] higher;
  logic            has_lower;
  logic            has_higher;
  logic [PixW-1:0] dist_lo;
  logic [PixW-1:0] dist_hi;

  // edge neighbours first, then diagonals
  always_comb begin
    centre = centre_i.mid;
    nb[0]  = centre_i.top;
    nb[1]  = left_i.mid;
    nb[2]  = right_i.mid;
    nb[3]  = centre_i.bot;
    nb[4]  = left_i.top;
    nb[5]  = right_i.top;
    nb[6]  = left_i.bot;
    nb[7]  = right_i.bot;
    use_nb = {{4{cfg_i.eight_connected}}, 4'hF};
  end

  // largest value below the centre and smallest value above it
  always_comb begin
    lower      = '0;
    higher     = '0;
    has_lower  = 1'b0;
    has_higher = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (use_nb[k]) begin
        if (nb[k] < centre) begin
          if (!has_lower || nb[k] > lower) lower = nb[k];
          has_lower = 1'b1;
        end else if (nb[k] > centre) begin
          if (!has_higher || nb[k] < higher) higher = nb[k];
          has_higher = 1'b1;
        end
      end
    end
  end

  // distances, zero where no such neighbour exists
  assign dist_lo = has_lower  ? centre - lower  : '0;
  assign dist_hi = has_higher ? higher - centre : '0;

  // mode select, unused mode gives zero
  always_comb begin
    unique case (sep_mode_e'(cfg_i.separation_mode))
      MODE_LOWER:  separation_o = dist_lo;
      MODE_HIGHER: separation_o = dist_hi;
      MODE_NEAREST: begin
        if (has_lower && has_higher) begin
          separation_o = (dist_lo < dist_hi) ? dist_lo : dist_hi;
        end else if (has_lower) begin
          separation_o = dist_lo;
        end else begin
          separation_o = dist_hi;
        end
      end
      default:     separation_o = '0;
    endcase
  end

endmodule

// ===== rtl/core/neighbour_gray_separation.sv =====
// top level of the 3x3 neighbor gray separation filter
//
// Pixels enter in raster order on the input channel (in_valid_i, in_stall_o,
// pixel_i), one request per pixel. For every interior pixel of the image one
// result leaves on the output channel (out_valid_o, out_stall_i) with its
// separation, column, row and a last flag on the final interior pixel;
// border pixels give no result. An image of W x H pixels gives (W-2)x(H-2)
// results.
// Throughput is one pixel per clock while the skid register is empty. The
// result of a window reaches the output register after the registered line
// store read and the window cell shift of the pixel that completes it; the
// neighbor compare sits in front of the output register. When the receiver
// stalls, the result in flight drops into a one-entry skid register; only
// when that skid register is full does in_stall_o rise and the whole
// pipeline hold. in_stall_o is a register and does not follow out_stall_i in
// the same cycle. Reset clears the position counters, window and handshake
// state and loads width 1024, height 3, eight neighbors and mode 0; the line
// stores are not cleared and need no clearing pass. The user must write
// configuration only while idle; the block itself does not enforce it.
module neighbour_gray_separation #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ngs_pkg::PixW-1:0]     pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ngs_pkg::PixW-1:0]     separation_o,
  output logic [ngs_pkg::ColW-1:0]     column_o,
  output logic [ngs_pkg::RowW-1:0]     row_o,
  output logic                         last_o,
  input  logic                         cfg_we_i,
  input  logic [ngs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ngs_pkg::CfgDataW-1:0] cfg_data_i
);
  import ngs_pkg::*;

  `include "neighbour_gray_separation_assert.svh"

  localparam int AddrW = $clog2(MAX_WIDTH);

  // configuration registers
  logic [WidthW-1:0] image_width_q;
  logic [RowW-1:0]   image_height_q;
  logic              eight_connected_q;
  logic [1:0]        separation_mode_q;

  // position of the next incoming pixel
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  // pipeline control and data
  logic            b_valid_q;
  meta_t           meta_b_q;
  logic [PixW-1:0] px_b_q;
  logic            c_valid_q;
  meta_t           meta_c_q;
  logic            out_valid_q;
  res_t            out_q;
  logic            skid_valid_q;
  res_t            skid_q;

  logic              advance;
  logic              accept;
  logic              taken;
  logic [WidthW-1:0] w_eff;
  logic [RowW-1:0]   h_eff;
  logic [WidthW-1:0] col_inc;
  logic [RowW:0]     row_inc;
  logic              col_wrap;
  logic              row_wrap;
  meta_t             meta_a;
  logic [PixW-1:0]   upper_rd;
  logic [PixW-1:0]   middle_rd;
  logic              shift;
  col_t              col_new;
  col_t              win_left;
  col_t              win_centre;
  col_t              win_right;
  sep_cfg_t          sep_cfg;
  logic [PixW-1:0]   sep_val;
  res_t              res_c;

  // whole pipeline moves unless the skid register holds a result
  assign advance    = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && advance;
  assign taken      = out_valid_q && !out_stall_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q     <= WidthW'(1024);
      image_height_q    <= RowW'(MinDim);
      eight_connected_q <= 1'b1;
      separation_mode_q <= MODE_LOWER;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:     image_width_q     <= cfg_data_i[WidthW-1:0];
        CFG_IMAGE_HEIGHT:    image_height_q    <= cfg_data_i[RowW-1:0];
        CFG_EIGHT_CONNECTED: eight_connected_q <= cfg_data_i[0];
        CFG_SEPARATION_MODE: separation_mode_q <= cfg_data_i[1:0];
        default:             ;
      endcase
    end
  end

  // effective image size, clamped to the supported range
  always_comb begin
    if (image_width_q < WidthW'(MinDim)) begin
      w_eff = WidthW'(MinDim);
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      w_eff = WidthW'(MAX_WIDTH);
    end else begin
      w_eff = image_width_q;
    end
    h_eff = (image_height_q < RowW'(MinDim)) ? RowW'(MinDim) : image_height_q;
  end

  // position bookkeeping for the accepted pixel
  always_comb begin
    col_inc       = {1'b0, col_q} + WidthW'(1);
    row_inc       = {1'b0, row_q} + (RowW+1)'(1);
    col_wrap      = col_inc >= w_eff;
    row_wrap      = row_inc >= {1'b0, h_eff};
    meta_a.emit   = (row_q >= RowW'(2)) && (col_q >= ColW'(2)) &&
                    (row_q < h_eff) && ({1'b0, col_q} < w_eff);
    meta_a.last   = (row_inc == {1'b0, h_eff}) && (col_inc == w_eff);
    meta_a.column = col_q - ColW'(1);
    meta_a.row    = row_q - RowW'(1);
    if (col_wrap) begin
      col_d = '0;
      row_d = row_wrap ? '0 : row_inc[RowW-1:0];
    end else begin
      col_d = col_inc[ColW-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line stores, read at accept and written back one stage later
  ngs_line_store #(
    .Depth (MAX_WIDTH),
    .AddrW (AddrW)
  ) u_line_store (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .rd_addr_i  (AddrW'(col_q)),
    .wr_en_i    (shift),
    .wr_addr_i  (AddrW'(meta_b_q.column + ColW'(1))),
    .wr_pixel_i (px_b_q),
    .upper_o    (upper_rd),
    .middle_o   (middle_rd)
  );

  // stage b: pixel and bookkeeping next to the line store read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (advance) begin
      b_valid_q <= accept;
      c_valid_q <= b_valid_q && meta_b_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meta_b_q <= meta_a;
      px_b_q   <= pixel_i;
    end
    if (shift) begin
      meta_c_q <= meta_b_q;
    end
  end

  // window: a chain of three column cells, newest on the right
  assign shift       = advance && b_valid_q;
  assign col_new.top = upper_rd;
  assign col_new.mid = middle_rd;
  assign col_new.bot = px_b_q;

  ngs_col_cell u_cell_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift),
    .col_i   (col_new),
    .col_o   (win_right)
  );

  ngs_col_cell u_cell_centre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift),
    .col_i   (win_right),
    .col_o   (win_centre)
  );

  ngs_col_cell u_cell_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift),
    .col_i   (win_centre),
    .col_o   (win_left)
  );

  // neighbor compare on the settled window
  assign sep_cfg.eight_connected = eight_connected_q;
  assign sep_cfg.separation_mode = separation_mode_q;

  ngs_contrast u_contrast (
    .left_i       (win_left),
    .centre_i     (win_centre),
    .right_i      (win_right),
    .cfg_i        (sep_cfg),
    .separation_o (sep_val)
  );

  assign res_c.separation = sep_val;
  assign res_c.column     = meta_c_q.column;
  assign res_c.row        = meta_c_q.row;
  assign res_c.last       = meta_c_q.last;

  // output register with one-entry skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (taken) begin
        skid_valid_q <= 1'b0;
      end
    end else if (c_valid_q) begin
      if (out_valid_q && !taken) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (taken) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (taken) begin
        out_q <= skid_q;
      end
    end else if (c_valid_q) begin
      if (out_valid_q && !taken) begin
        skid_q <= res_c;
      end else begin
        out_q <= res_c;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign separation_o = out_q.separation;
  assign column_o     = out_q.column;
  assign row_o        = out_q.row;
  assign last_o       = out_q.last;

  // checks
  `NGS_ASSERT(a_skid_needs_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q)
  `NGS_ASSERT(a_skid_on_stall, clk_i, rst_ni, $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
  `NGS_ASSERT_NEVER(a_border_result, clk_i, rst_ni, out_valid_o && (column_o == '0 || row_o == '0))

endmodule
